/* rtl/lft_pkg.sv */
// Shared types and character codes for the LTL formula tokenizer.
package lft_pkg;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        TK_NEG   = 4'd0,
        TK_IMPL  = 4'd1,
        TK_EQUIV = 4'd2,
        TK_EVENT = 4'd3,
        TK_AND   = 4'd4,
        TK_OR    = 4'd5,
        TK_ALW   = 4'd6,
        TK_UNTIL = 4'd7,
        TK_REL   = 4'd8,
        TK_NEXT  = 4'd9,
        TK_LPAR  = 4'd10,
        TK_RPAR  = 4'd11,
        TK_ID    = 4'd12,
        TK_END   = 4'd13,
        TK_ERR   = 4'd14
    } tok_kind_t;

    // Most tokens one input byte can cause.
    localparam int unsigned GRP_MAX = 3;

    // All tokens caused by one input byte. Only the last one can be an idchar.
    typedef struct packed {
        logic [1:0]                count;
        tok_kind_t [GRP_MAX-1:0]   kind;
        logic [7:0]                id_byte;
        logic                      id_last;
    } grp_t;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

/* rtl/lft_channels.sv */
// Valid/ready channel interfaces for formula bytes and result tokens.
interface lft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lft_tok_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] id_byte;
    logic       id_last;
    logic       run_last;

    modport source (output valid, output token_kind, output id_byte,
                    output id_last, output run_last, input ready);
    modport sink   (input valid, input token_kind, input id_byte,
                    input id_last, input run_last, output ready);
endinterface

/* rtl/lft_lexer.sv */
// Lookahead state and per-byte token decode.
module lft_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    in_byte,
    output lft_pkg::grp_t grp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MINUS,
        ST_LT,
        ST_LTMINUS,
        ST_AMP,
        ST_BAR,
        ST_LBRK,
        ST_ATOM
    } lex_state_t;

    lex_state_t          state_reg;
    lex_state_t          state_next;

    // Decode of the byte as if seen from idle
    logic                idle_has;
    lft_pkg::tok_kind_t  idle_kind;
    lex_state_t          idle_ns;

    logic                relex;
    logic [1:0]          errs;
    lft_pkg::tok_kind_t  done_kind;
    logic                done_has;

    always_comb
    begin
        idle_has  = 1'b1;
        idle_kind = lft_pkg::TK_NEG;
        idle_ns   = ST_IDLE;
        case (in_byte)
            lft_pkg::CH_BANG:   idle_kind = lft_pkg::TK_NEG;
            lft_pkg::CH_U:      idle_kind = lft_pkg::TK_UNTIL;
            lft_pkg::CH_V:      idle_kind = lft_pkg::TK_REL;
            lft_pkg::CH_X:      idle_kind = lft_pkg::TK_NEXT;
            lft_pkg::CH_LPAR:   idle_kind = lft_pkg::TK_LPAR;
            lft_pkg::CH_RPAR:   idle_kind = lft_pkg::TK_RPAR;
            lft_pkg::CH_NUL,
            lft_pkg::CH_HASH:   idle_kind = lft_pkg::TK_END;
            lft_pkg::CH_LBRACE:
            begin
                idle_kind = lft_pkg::TK_ID;
                idle_ns   = ST_ATOM;
            end
            lft_pkg::CH_MINUS:
            begin
                idle_has = 1'b0;
                idle_ns  = ST_MINUS;
            end
            lft_pkg::CH_LT:
            begin
                idle_has = 1'b0;
                idle_ns  = ST_LT;
            end
            lft_pkg::CH_AMP:
            begin
                idle_has = 1'b0;
                idle_ns  = ST_AMP;
            end
            lft_pkg::CH_BAR:
            begin
                idle_has = 1'b0;
                idle_ns  = ST_BAR;
            end
            lft_pkg::CH_LBRK:
            begin
                idle_has = 1'b0;
                idle_ns  = ST_LBRK;
            end
            default:            idle_has = 1'b0;
        endcase
    end

    always_comb
    begin
        relex      = 1'b0;
        errs       = 2'd0;
        done_has   = 1'b0;
        done_kind  = lft_pkg::TK_ERR;
        state_next = ST_IDLE;
        grp        = '0;

        case (state_reg)
            ST_ATOM:
            begin
                grp.count   = 2'd1;
                grp.kind[0] = lft_pkg::TK_ID;
                grp.id_byte = in_byte;
                grp.id_last = (in_byte == lft_pkg::CH_RBRACE);
                state_next  = grp.id_last ? ST_IDLE : ST_ATOM;
            end
            ST_MINUS:
            begin
                done_has  = (in_byte == lft_pkg::CH_GT);
                done_kind = lft_pkg::TK_IMPL;
                relex     = !done_has;
                errs      = 2'd1;
            end
            ST_LT:
            begin
                if (in_byte == lft_pkg::CH_MINUS)
                begin
                    state_next = ST_LTMINUS;
                end
                else
                begin
                    done_has  = (in_byte == lft_pkg::CH_GT);
                    done_kind = lft_pkg::TK_EVENT;
                    relex     = !done_has;
                    errs      = 2'd1;
                end
            end
            ST_LTMINUS:
            begin
                // Both the '<' and the '-' break on a byte other than '>'
                done_has  = (in_byte == lft_pkg::CH_GT);
                done_kind = lft_pkg::TK_EQUIV;
                relex     = !done_has;
                errs      = 2'd2;
            end
            ST_AMP:
            begin
                done_has  = (in_byte == lft_pkg::CH_AMP);
                done_kind = lft_pkg::TK_AND;
                relex     = !done_has;
                errs      = 2'd1;
            end
            ST_BAR:
            begin
                done_has  = (in_byte == lft_pkg::CH_BAR);
                done_kind = lft_pkg::TK_OR;
                relex     = !done_has;
                errs      = 2'd1;
            end
            ST_LBRK:
            begin
                done_has  = (in_byte == lft_pkg::CH_RBRK);
                done_kind = lft_pkg::TK_ALW;
                relex     = !done_has;
                errs      = 2'd1;
            end
            default:
            begin
                relex = 1'b1;
                errs  = 2'd0;
            end
        endcase

        if (done_has)
        begin
            grp.count   = 2'd1;
            grp.kind[0] = done_kind;
        end

        if (relex)
        begin
            if (errs != 2'd0)
            begin
                grp.kind[0] = lft_pkg::TK_ERR;
            end
            if (errs == 2'd2)
            begin
                grp.kind[1] = lft_pkg::TK_ERR;
            end
            state_next = idle_ns;
            if (idle_has)
            begin
                grp.count     = errs + 2'd1;
                grp.kind[errs] = idle_kind;
                if (idle_kind == lft_pkg::TK_ID)
                begin
                    grp.id_byte = in_byte;
                end
            end
            else
            begin
                grp.count = errs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/ltl_formula_tokenizer.sv */
// Top level: LTL formula tokenizer with a two-group result queue.
//
// The block takes one formula byte per transfer on the chars channel and
// gives result tokens, one per transfer, on the tokens channel. A byte is
// accepted in every cycle in which the result queue has a free slot; the
// queue holds the tokens of two bytes, so the input keeps moving while
// results wait to be taken. A byte yields zero to three tokens: most give
// one, an operator prefix ('-', '<', "<-", '&', '|', '[') gives none until
// it is completed, and a broken prefix gives one or two error tokens ahead
// of the relexed byte. The sustained input rate is one byte per cycle as
// long as each byte yields at most one token and the sink is ready; a byte
// that yields several tokens holds the output until all are taken, so the
// byte rate is then set by the output port at one token per cycle. run_last
// marks the final token caused by each byte. Atom text from '{' through '}'
// comes out as idchar tokens, the closing brace flagged by id_last. Bytes
// that start no token are consumed without a result.
module ltl_formula_tokenizer (
    input  logic            clk,
    input  logic            rst_n,
    lft_byte_if.sink        chars,
    lft_tok_if.source       tokens
);

    lft_pkg::grp_t  grp;
    logic           take;
    logic           push;
    logic           pop;
    logic           tok_xfer;
    logic           last_tok;

    // Two-slot queue of token groups
    lft_pkg::grp_t  q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [1:0]     pos_reg;
    logic [1:0]     pos_next;
    lft_pkg::grp_t  head;

    assign chars.ready = (cnt_reg != 2'd2);
    assign take        = chars.valid && chars.ready;
    assign push        = take && (grp.count != 2'd0);

    lft_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (chars.in_byte),
        .grp     (grp)
    );

    // Output side reads the head group one token at a time
    assign head     = q_reg[rd_ptr_reg];
    assign last_tok = (pos_reg == (head.count - 2'd1));
    assign tok_xfer = tokens.valid && tokens.ready;
    assign pop      = tok_xfer && last_tok;

    assign tokens.valid      = (cnt_reg != 2'd0);
    assign tokens.token_kind = head.kind[pos_reg];
    assign tokens.id_byte    = last_tok ? head.id_byte : 8'd0;
    assign tokens.id_last    = last_tok && head.id_last;
    assign tokens.run_last   = last_tok;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
        if (pop)
        begin
            pos_next = 2'd0;
        end
        else if (tok_xfer)
        begin
            pos_next = pos_reg + 2'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            pos_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
        end
    end

    // Group payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= grp;
        end
    end

`ifndef SYNTHESIS
    // Queue never holds more than two groups
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue overflow");

    // Token index stays inside the head group
    a_pos_in_grp: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid |-> (pos_reg < head.count))
        else $error("token index beyond head group");

    // Closing brace flag only on an idchar
    a_id_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.id_last) |->
            (tokens.token_kind == lft_pkg::TK_ID) && tokens.run_last)
        else $error("id_last on a non-idchar token");

    // Identifier byte is zero except on idchar tokens
    a_id_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind != lft_pkg::TK_ID)) |->
            (tokens.id_byte == 8'd0))
        else $error("id_byte set on a non-idchar token");

    // A full queue blocks input until a group retires
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg == 2'd2) && !pop) |=> (cnt_reg == 2'd2))
        else $error("queue lost a group without a pop");
`endif

endmodule
